// File: rtl/core/uft_pkg.sv
package uft_pkg;

   localparam int MAX_URL_LEN = 1024;
   localparam int POS_W       = $clog2(MAX_URL_LEN + 1);

   localparam int BURST_MAX   = 3;
   localparam int BCNT_W      = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QIDX_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_PERCENT = 8'h25;

   typedef enum logic [3:0] {
      ST_START   = 4'd0,
      ST_PROTOCOL = 4'd1,
      ST_SLASH1  = 4'd2,
      ST_SLASH2  = 4'd3,
      ST_HOST    = 4'd4,
      ST_PREPORT = 4'd5,
      ST_PORT    = 4'd6,
      ST_SEGMENT = 4'd7,
      ST_KEY     = 4'd8,
      ST_VALUE   = 4'd9,
      ST_ERROR   = 4'd10
   } uft_state_type;

   typedef enum logic [3:0] {
      EV_BEGIN     = 4'd0,
      EV_PROTOCOL  = 4'd1,
      EV_HOST      = 4'd2,
      EV_PORT      = 4'd3,
      EV_SEGMENT   = 4'd4,
      EV_PATH      = 4'd5,
      EV_KEY_VALUE = 4'd6,
      EV_COMPLETE  = 4'd7,
      EV_ERROR     = 4'd8
   } uft_kind_type;

   typedef struct packed {
      uft_kind_type kind;
      logic [9:0]   first_start;
      logic [10:0]  first_length;
      logic [9:0]   second_start;
      logic [10:0]  second_length;
      logic         last;
   } uft_event_type;

   typedef struct packed {
      uft_event_type [BURST_MAX-1:0] ev;
      logic [BCNT_W-1:0]             count;
   } uft_burst_type;

endpackage

// File: rtl/core/uft_parser.sv
module uft_parser import uft_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          take,
   input  logic          end_item,
   input  logic [7:0]    char_in,
   input  logic [7:0]    event_mask,
   output uft_burst_type burst
);

   uft_state_type    state_ff, state_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [POS_W-1:0] protocol_begin_ff, protocol_begin_in;
   logic [9:0]       host_begin_ff, host_begin_in;
   logic [10:0]      host_count_ff, host_count_in;
   logic [9:0]       port_begin_ff, port_begin_in;
   logic [10:0]      port_count_ff, port_count_in;
   logic [9:0]       path_begin_ff, path_begin_in;
   logic [10:0]      path_count_ff, path_count_in;
   logic [9:0]       segment_begin_ff, segment_begin_in;
   logic [10:0]      segment_count_ff, segment_count_in;
   logic [9:0]       key_begin_ff, key_begin_in;
   logic [10:0]      key_count_ff, key_count_in;
   logic [9:0]       value_begin_ff, value_begin_in;
   logic [10:0]      value_count_ff, value_count_in;

   uft_event_type [BURST_MAX-1:0] raw;
   logic [BURST_MAX-1:0]          raw_valid;
   logic [BURST_MAX-1:0]          keep;
   logic [BCNT_W-1:0]             n;
   logic [9:0]                    pos10;
   logic [9:0]                    pos_next10;
   logic                          advance;
   logic                          ok_end;

   function automatic logic legal_char(input logic [7:0] c);
      logic r;
      case (c) inside
         ["0":"9"], ["A":"Z"], ["a":"z"],
         "-", ".", "_", "~", ":", "/", "?", "#", "[", "]", "@", "!", "$",
         "&", "'", "(", ")", "*", "+", ",", ";", "=", CH_PERCENT: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic uft_event_type make_event(input uft_kind_type k,
                                                input logic [9:0] s1,
                                                input logic [10:0] l1,
                                                input logic [9:0] s2,
                                                input logic [10:0] l2);
      uft_event_type e;
      e.kind          = k;
      e.first_start   = s1;
      e.first_length  = l1;
      e.second_start  = s2;
      e.second_length = l2;
      e.last          = 1'b0;
      return e;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_START;
         position_ff       <= '0;
         protocol_begin_ff <= '0;
         host_begin_ff     <= '0;
         host_count_ff     <= '0;
         port_begin_ff     <= '0;
         port_count_ff     <= '0;
         path_begin_ff     <= '0;
         path_count_ff     <= '0;
         segment_begin_ff  <= '0;
         segment_count_ff  <= '0;
         key_begin_ff      <= '0;
         key_count_ff      <= '0;
         value_begin_ff    <= '0;
         value_count_ff    <= '0;
      end else if (take) begin
         state_ff          <= state_in;
         position_ff       <= position_in;
         protocol_begin_ff <= protocol_begin_in;
         host_begin_ff     <= host_begin_in;
         host_count_ff     <= host_count_in;
         port_begin_ff     <= port_begin_in;
         port_count_ff     <= port_count_in;
         path_begin_ff     <= path_begin_in;
         path_count_ff     <= path_count_in;
         segment_begin_ff  <= segment_begin_in;
         segment_count_ff  <= segment_count_in;
         key_begin_ff      <= key_begin_in;
         key_count_ff      <= key_count_in;
         value_begin_ff    <= value_begin_in;
         value_count_ff    <= value_count_in;
      end
   end

   assign pos10      = 10'(position_ff);
   assign pos_next10 = 10'(position_ff + POS_W'(1));

   always_comb begin
      state_in          = state_ff;
      position_in       = position_ff;
      protocol_begin_in = protocol_begin_ff;
      host_begin_in     = host_begin_ff;
      host_count_in     = host_count_ff;
      port_begin_in     = port_begin_ff;
      port_count_in     = port_count_ff;
      path_begin_in     = path_begin_ff;
      path_count_in     = path_count_ff;
      segment_begin_in  = segment_begin_ff;
      segment_count_in  = segment_count_ff;
      key_begin_in      = key_begin_ff;
      key_count_in      = key_count_ff;
      value_begin_in    = value_begin_ff;
      value_count_in    = value_count_ff;
      raw               = '0;
      raw_valid         = '0;
      advance           = 1'b1;
      ok_end            = 1'b1;

      if (end_item) begin
         advance = 1'b0;
         unique case (state_ff)
            ST_SEGMENT: begin
               raw[0] = make_event(EV_SEGMENT, segment_begin_ff, segment_count_ff, '0, '0);
               raw[1] = make_event(EV_PATH, path_begin_ff, path_count_ff, '0, '0);
               raw_valid[1:0] = 2'b11;
            end
            ST_VALUE: begin
               raw[0] = make_event(EV_KEY_VALUE, key_begin_ff, key_count_ff,
                                   value_begin_ff, value_count_ff);
               raw_valid[0] = 1'b1;
            end
            ST_HOST: begin
               raw[0] = make_event(EV_HOST, host_begin_ff, host_count_ff, '0, '0);
               raw_valid[0] = 1'b1;
            end
            ST_PORT: begin
               raw[0] = make_event(EV_PORT, port_begin_ff, port_count_ff, '0, '0);
               raw_valid[0] = 1'b1;
            end
            default: ok_end = 1'b0;
         endcase
         if (ok_end) begin
            raw[2] = make_event(EV_COMPLETE, '0, 11'(position_ff), '0, '0);
         end else begin
            raw[2] = make_event(EV_ERROR, '0, '0, '0, '0);
         end
         raw_valid[2]      = 1'b1;
         state_in          = ST_START;
         position_in       = '0;
         protocol_begin_in = '0;
         host_begin_in     = '0;
         host_count_in     = '0;
         port_begin_in     = '0;
         port_count_in     = '0;
         path_begin_in     = '0;
         path_count_in     = '0;
         segment_begin_in  = '0;
         segment_count_in  = '0;
         key_begin_in      = '0;
         key_count_in      = '0;
         value_begin_in    = '0;
         value_count_in    = '0;
      end else if (state_ff == ST_ERROR) begin
         advance = 1'b0;
      end else if (!legal_char(char_in) || position_ff >= POS_W'(MAX_URL_LEN)) begin
         advance  = 1'b0;
         state_in = ST_ERROR;
      end else begin
         unique case (state_ff)
            ST_START: begin
               raw[0]       = make_event(EV_BEGIN, '0, '0, '0, '0);
               raw_valid[0] = 1'b1;
               if (char_in == CH_SLASH) begin
                  state_in         = ST_SEGMENT;
                  path_begin_in    = pos10;
                  path_count_in    = path_count_ff + 11'd1;
                  segment_begin_in = pos_next10;
               end else begin
                  state_in          = ST_PROTOCOL;
                  protocol_begin_in = position_ff;
               end
            end
            ST_PROTOCOL: begin
               if (char_in == CH_COLON) begin
                  raw[0] = make_event(EV_PROTOCOL, 10'(protocol_begin_ff),
                                      11'(position_ff - protocol_begin_ff), '0, '0);
                  raw_valid[0] = 1'b1;
                  state_in     = ST_SLASH1;
               end
            end
            ST_SLASH1: begin
               state_in = (char_in == CH_SLASH) ? ST_SLASH2 : ST_ERROR;
            end
            ST_SLASH2: begin
               if (char_in == CH_SLASH) begin
                  state_in      = ST_HOST;
                  host_begin_in = pos_next10;
               end else begin
                  state_in = ST_ERROR;
               end
            end
            ST_HOST: begin
               if (char_in == CH_COLON || char_in == CH_SLASH) begin
                  raw[0]       = make_event(EV_HOST, host_begin_ff, host_count_ff, '0, '0);
                  raw_valid[0] = 1'b1;
                  if (char_in == CH_COLON) begin
                     state_in = ST_PREPORT;
                  end else begin
                     state_in         = ST_SEGMENT;
                     path_begin_in    = pos10;
                     path_count_in    = path_count_ff + 11'd1;
                     segment_begin_in = pos_next10;
                  end
               end else begin
                  host_count_in = host_count_ff + 11'd1;
               end
            end
            ST_PREPORT: begin
               if (char_in == CH_SLASH) begin
                  state_in = ST_ERROR;
               end else begin
                  state_in      = ST_PORT;
                  port_begin_in = pos10;
                  port_count_in = port_count_ff + 11'd1;
               end
            end
            ST_PORT: begin
               if (char_in == CH_SLASH) begin
                  raw[0]           = make_event(EV_PORT, port_begin_ff, port_count_ff, '0, '0);
                  raw_valid[0]     = 1'b1;
                  state_in         = ST_SEGMENT;
                  path_begin_in    = pos10;
                  path_count_in    = path_count_ff + 11'd1;
                  segment_begin_in = pos_next10;
               end else begin
                  port_count_in = port_count_ff + 11'd1;
               end
            end
            ST_SEGMENT: begin
               if (char_in == CH_SLASH || char_in == CH_QUEST) begin
                  raw[0] = make_event(EV_SEGMENT, segment_begin_ff, segment_count_ff,
                                      '0, '0);
                  raw_valid[0]     = 1'b1;
                  segment_begin_in = pos_next10;
                  segment_count_in = '0;
               end else begin
                  segment_count_in = segment_count_ff + 11'd1;
               end
               if (char_in == CH_QUEST) begin
                  raw[1]       = make_event(EV_PATH, path_begin_ff, path_count_ff, '0, '0);
                  raw_valid[1] = 1'b1;
                  state_in     = ST_KEY;
                  key_begin_in = pos_next10;
               end else begin
                  path_count_in = path_count_ff + 11'd1;
               end
            end
            ST_KEY: begin
               if (char_in == CH_EQUAL) begin
                  state_in       = ST_VALUE;
                  value_begin_in = pos_next10;
                  value_count_in = '0;
               end else begin
                  key_count_in = key_count_ff + 11'd1;
               end
            end
            ST_VALUE: begin
               if (char_in == CH_AMP) begin
                  raw[0] = make_event(EV_KEY_VALUE, key_begin_ff, key_count_ff,
                                      value_begin_ff, value_count_ff);
                  raw_valid[0] = 1'b1;
                  state_in     = ST_KEY;
                  key_begin_in = pos_next10;
                  key_count_in = '0;
               end else begin
                  value_count_in = value_count_ff + 11'd1;
               end
            end
            default: begin
               advance  = 1'b0;
               state_in = ST_ERROR;
            end
         endcase
      end

      if (advance) begin
         position_in = position_ff + POS_W'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < BURST_MAX; i++) begin
         keep[i] = raw_valid[i] &&
                   (raw[i].kind == EV_ERROR || event_mask[raw[i].kind[2:0]]);
      end
   end

   // pack surviving events to the front and flag the final one
   always_comb begin
      burst.ev = '0;
      n        = '0;
      for (int i = 0; i < BURST_MAX; i++) begin
         if (keep[i]) begin
            burst.ev[n] = raw[i];
            n           = n + BCNT_W'(1);
         end
      end
      if (n != '0) begin
         burst.ev[n - BCNT_W'(1)].last = 1'b1;
      end
      burst.count = n;
   end

endmodule

// File: rtl/core/uft_queue.sv
module uft_queue import uft_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  uft_burst_type burst,
   output logic          can_take,
   output uft_event_type head,
   output logic          head_valid,
   input  logic          head_ready
);

   uft_event_type     slot_ff [QUEUE_DEPTH];
   uft_event_type     slot_in [QUEUE_DEPTH];
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QCNT_W-1:0] base;
   logic [QCNT_W-1:0] diff;
   logic [BCNT_W-1:0] n;
   logic              pop;

   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[0];
   assign can_take   = (count_ff <= QCNT_W'(1));
   assign pop        = head_valid && head_ready;
   assign n          = push ? burst.count : '0;
   assign base       = count_ff - QCNT_W'(pop);
   assign count_in   = base + QCNT_W'(n);

   // shift out the head, then append the new burst behind what remains
   always_comb begin
      diff = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
         if (QCNT_W'(i) < base) begin
            slot_in[i] = slot_ff[QIDX_W'(i) + QIDX_W'(pop)];
         end else begin
            diff = QCNT_W'(i) - base;
            if (diff < QCNT_W'(n)) begin
               slot_in[i] = burst.ev[diff[BCNT_W-1:0]];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("event queue overfilled");

   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> slot_ff[QIDX_W'(count_ff - QCNT_W'(1))].last)
      else $error("queue tail is not the end of a run");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - QCNT_W'(1)))
      else $error("queue count did not drop after a pop");

endmodule

// File: rtl/core/url_field_tokenizer_unit.sv
// URL field tokenizer.
// req channel: one request per URL character (req_tuser = 0, character in
// req_tdata) or an end-of-URL request (req_tuser = 1). rsp channel: field
// events, kind in rsp_tuser, start/length pairs in rsp_tdata, rsp_tlast on
// the final event caused by one request. A request may cause zero to three
// events. csr_wr_en/csr_wr_data write the 8-bit event enable mask.
// A request is parsed in the cycle it is accepted; its events are registered
// into a four-entry event queue behind any events still queued.
// Requests are accepted while the queue holds at most one event, so a
// stream with one event or less per request runs at one request per cycle while
// rsp_tready is high; otherwise rsp drains one event per cycle and sets the rate.
// Reset (synchronous) empties the queue, returns the parser to its start
// state with all positions and counts zero, and enables every event.
// When the receiver stalls, the queue fills and req_tready drops; no event
// is lost or reordered.
module url_field_tokenizer_unit import uft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // character[7:0]
   input  logic        req_tuser,   // action[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // first_start[9:0], first_length[20:10],
                                    // second_start[30:21], second_length[41:31], zero
   output logic [3:0]  rsp_tuser,   // event_kind[3:0]
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic [7:0]    event_mask_ff;
   logic          accept;
   logic          can_take;
   uft_burst_type burst;
   uft_event_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         event_mask_ff <= 8'hFF;
      end else if (csr_wr_en) begin
         event_mask_ff <= csr_wr_data;
      end
   end

   assign req_tready = can_take;
   assign accept     = req_tvalid && can_take;

   uft_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .take       (accept),
      .end_item   (req_tuser),
      .char_in    (req_tdata),
      .event_mask (event_mask_ff),
      .burst      (burst)
   );

   uft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .burst      (burst),
      .can_take   (can_take),
      .head       (head),
      .head_valid (rsp_tvalid),
      .head_ready (rsp_tready)
   );

   assign rsp_tdata = {6'd0, head.second_length, head.second_start,
                       head.first_length, head.first_start};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

// File: dv/url_field_tokenizer_unit_tb.sv
module url_field_tokenizer_unit_tb import uft_pkg::*; ();

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_BUDGET = 120;

   localparam string URL_WORD =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-._~%@!$()*+,;[]#'";
   localparam string PROTO_SET = {URL_WORD, "?=&"};
   localparam string HOST_SET  = {URL_WORD, "?=&"};
   localparam string PORT_SET  = {URL_WORD, ":?=&"};
   localparam string SEG_SET   = {URL_WORD, ":=&"};
   localparam string KEY_SET   = {URL_WORD, ":/?&"};
   localparam string VAL_SET   = {URL_WORD, ":/?="};

   typedef struct packed {
      logic       action;
      logic [7:0] ch;
   } url_request_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;

   url_request_type pending_reqs[$];
   url_request_type next_req;
   logic [7:0]      url_chars[$];
   uft_event_type   step_events[$];
   uft_event_type   expected_events[$];
   uft_event_type   want;

   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int pushed_count  = 0;
   int mismatch_count = 0;
   int cycle_count   = 0;
   int gap_by_phase[4]   = '{0, 50, 0, 9};
   int stall_by_phase[4] = '{0, 0, 50, 9};
   int phase_start;

   // tokenizer state
   logic [7:0]    enable_mask;
   uft_state_type url_state;
   logic [10:0]   url_pos, proto_at, host_at, host_len, port_at, port_len;
   logic [10:0]   path_at, path_len, seg_at, seg_len, key_at, key_len, val_at, val_len;

   url_field_tokenizer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic is_url_char(input logic [7:0] c);
      case (c)
         "-", ".", "_", "~", ":", "/", "?", "#", "[", "]", "@", "!", "$", "&", "'",
         "(", ")", "*", "+", ",", ";", "=", "%": return 1'b1;
         default: return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                         (c >= "a" && c <= "z");
      endcase
   endfunction

   function automatic void reset_parse();
      url_state = ST_START;
      url_pos = '0;  proto_at = '0;
      host_at = '0;  host_len = '0;
      port_at = '0;  port_len = '0;
      path_at = '0;  path_len = '0;
      seg_at = '0;   seg_len = '0;
      key_at = '0;   key_len = '0;
      val_at = '0;   val_len = '0;
   endfunction

   function automatic void post_event(input uft_kind_type kind, input logic [10:0] s1,
                                      input logic [10:0] l1, input logic [10:0] s2,
                                      input logic [10:0] l2);
      uft_event_type ev;
      if (kind < EV_ERROR && !enable_mask[kind[2:0]]) return;
      if (step_events.size() >= BURST_MAX) return;
      ev.kind          = kind;
      ev.first_start   = s1[9:0];
      ev.first_length  = l1;
      ev.second_start  = s2[9:0];
      ev.second_length = l2;
      ev.last          = 1'b0;
      step_events.push_back(ev);
   endfunction

   function automatic void open_path();
      url_state = ST_SEGMENT;
      path_at   = url_pos;
      path_len  = path_len + 11'd1;
      seg_at    = url_pos + 11'd1;
   endfunction

   function automatic void tokenize_request(input logic action, input logic [7:0] ch);
      uft_event_type ev;
      logic good;
      step_events.delete();
      if (action) begin
         good = 1'b1;
         case (url_state)
            ST_SEGMENT: begin
               post_event(EV_SEGMENT, seg_at, seg_len, '0, '0);
               post_event(EV_PATH, path_at, path_len, '0, '0);
            end
            ST_VALUE: post_event(EV_KEY_VALUE, key_at, key_len, val_at, val_len);
            ST_HOST:  post_event(EV_HOST, host_at, host_len, '0, '0);
            ST_PORT:  post_event(EV_PORT, port_at, port_len, '0, '0);
            default:  good = 1'b0;
         endcase
         if (good) post_event(EV_COMPLETE, '0, url_pos, '0, '0);
         else post_event(EV_ERROR, '0, '0, '0, '0);
         reset_parse();
      end else if (url_state != ST_ERROR) begin
         if (!is_url_char(ch) || url_pos >= MAX_URL_LEN) begin
            url_state = ST_ERROR;
         end else begin
            case (url_state)
               ST_START: begin
                  post_event(EV_BEGIN, '0, '0, '0, '0);
                  if (ch == CH_SLASH) begin
                     open_path();
                  end else begin
                     url_state = ST_PROTOCOL;
                     proto_at  = url_pos;
                  end
               end
               ST_PROTOCOL: begin
                  if (ch == CH_COLON) begin
                     post_event(EV_PROTOCOL, proto_at, url_pos - proto_at, '0, '0);
                     url_state = ST_SLASH1;
                  end
               end
               ST_SLASH1: url_state = (ch == CH_SLASH) ? ST_SLASH2 : ST_ERROR;
               ST_SLASH2: begin
                  if (ch == CH_SLASH) begin
                     url_state = ST_HOST;
                     host_at   = url_pos + 11'd1;
                  end else begin
                     url_state = ST_ERROR;
                  end
               end
               ST_HOST: begin
                  if (ch == CH_COLON || ch == CH_SLASH) begin
                     post_event(EV_HOST, host_at, host_len, '0, '0);
                     if (ch == CH_COLON) url_state = ST_PREPORT;
                     else open_path();
                  end else begin
                     host_len = host_len + 11'd1;
                  end
               end
               ST_PREPORT: begin
                  if (ch == CH_SLASH) begin
                     url_state = ST_ERROR;
                  end else begin
                     url_state = ST_PORT;
                     port_at   = url_pos;
                     port_len  = port_len + 11'd1;
                  end
               end
               ST_PORT: begin
                  if (ch == CH_SLASH) begin
                     post_event(EV_PORT, port_at, port_len, '0, '0);
                     open_path();
                  end else begin
                     port_len = port_len + 11'd1;
                  end
               end
               ST_SEGMENT: begin
                  if (ch == CH_SLASH || ch == CH_QUEST) begin
                     post_event(EV_SEGMENT, seg_at, seg_len, '0, '0);
                     seg_at  = url_pos + 11'd1;
                     seg_len = '0;
                  end else begin
                     seg_len = seg_len + 11'd1;
                  end
                  if (ch == CH_QUEST) begin
                     post_event(EV_PATH, path_at, path_len, '0, '0);
                     url_state = ST_KEY;
                     key_at    = url_pos + 11'd1;
                  end else begin
                     path_len = path_len + 11'd1;
                  end
               end
               ST_KEY: begin
                  if (ch == CH_EQUAL) begin
                     url_state = ST_VALUE;
                     val_at    = url_pos + 11'd1;
                     val_len   = '0;
                  end else begin
                     key_len = key_len + 11'd1;
                  end
               end
               ST_VALUE: begin
                  if (ch == CH_AMP) begin
                     post_event(EV_KEY_VALUE, key_at, key_len, val_at, val_len);
                     url_state = ST_KEY;
                     key_at    = url_pos + 11'd1;
                     key_len   = '0;
                  end else begin
                     val_len = val_len + 11'd1;
                  end
               end
               default: ;
            endcase
            url_pos = url_pos + 11'd1;
         end
      end
      foreach (step_events[i]) begin
         ev      = step_events[i];
         ev.last = (i == step_events.size() - 1);
         expected_events.push_back(ev);
      end
   endfunction

   function automatic void push_byte(input logic action, input logic [7:0] ch);
      url_request_type r;
      r.action = action;
      r.ch     = ch;
      pending_reqs.push_back(r);
      pushed_count++;
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) url_chars.push_back(s[i]);
   endfunction

   function automatic void add_run(input string chars, input int lo, input int hi);
      int n;
      n = $urandom_range(hi, lo);
      repeat (n) url_chars.push_back(chars[$urandom_range(chars.len() - 1, 0)]);
   endfunction

   // flush the built URL as requests, with an illegal byte at bad_at, then end it
   function automatic void send_url(input int bad_at);
      logic [7:0] b;
      foreach (url_chars[i]) begin
         if (i == bad_at) begin
            do b = 8'($urandom_range(0, 255)); while (is_url_char(b));
            push_byte(1'b0, b);
         end else begin
            push_byte(1'b0, url_chars[i]);
         end
      end
      push_byte(1'b1, 8'($urandom_range(0, 255)));
      url_chars.delete();
   endfunction

   function automatic void push_random_url();
      int form;
      int bad_at;
      int pairs;
      int cut;
      form   = $urandom_range(0, 99);
      bad_at = -1;
      if (form < 80) begin
         if ($urandom_range(0, 3) != 0) begin
            add_run(PROTO_SET, 1, 5);
            add_text("://");
            add_run(HOST_SET, 0, 6);
            if ($urandom_range(0, 2) == 0) begin
               add_text(":");
               add_run(PORT_SET, 1, 4);
            end
         end
         if (url_chars.size() == 0 || $urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 3)) begin
               add_text("/");
               add_run(SEG_SET, 0, 5);
            end
            if ($urandom_range(0, 1) == 1) begin
               add_text("?");
               pairs = $urandom_range(1, 3);
               for (int k = 0; k < pairs; k++) begin
                  if (k != 0) add_text("&");
                  add_run(KEY_SET, 0, 4);
                  add_text("=");
                  add_run(VAL_SET, 0, 4);
               end
            end
         end
         if ($urandom_range(0, 99) < 12) begin
            cut = $urandom_range(0, url_chars.size() - 1);
            while (url_chars.size() > cut) void'(url_chars.pop_back());
         end
         if (url_chars.size() != 0 && $urandom_range(0, 99) < 10)
            bad_at = $urandom_range(0, url_chars.size() - 1);
      end else if (form < 90) begin
         repeat ($urandom_range(1, 8)) url_chars.push_back(8'($urandom_range(0, 255)));
      end else begin
         add_run(PROTO_SET, 1, 4);
         case ($urandom_range(0, 3))
            0: begin
               add_text(":");
               add_run(URL_WORD, 1, 3);
            end
            1: begin
               add_text(":/");
               add_run(URL_WORD, 1, 3);
            end
            2: begin
               add_text("://");
               add_run(HOST_SET, 0, 3);
               add_text(":/");
               add_run(SEG_SET, 0, 3);
            end
            default: begin
               add_text("://");
               add_run(HOST_SET, 0, 3);
               add_text(":");
            end
         endcase
      end
      send_url(bad_at);
   endfunction

   function automatic void fill_random(input int budget);
      phase_start = pushed_count;
      while (pushed_count - phase_start < budget) push_random_url();
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_events.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mask(input logic [7:0] m);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      enable_mask = m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) tokenize_request(req_tuser, req_tdata);
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               next_req = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_req.action;
               req_tdata  <= next_req.ch;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // event monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected event: kind %0d tdata %h last %0b",
                           rsp_tuser, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_events.pop_front();
               if (want.kind != rsp_tuser || want.first_start != rsp_tdata[9:0] ||
                   want.first_length != rsp_tdata[20:10] ||
                   want.second_start != rsp_tdata[30:21] ||
                   want.second_length != rsp_tdata[41:31] || want.last != rsp_tlast) begin
                  if (mismatch_count < 10) begin
                     $display("event mismatch: expected kind %0d %0d/%0d %0d/%0d last %0b",
                              want.kind, want.first_start, want.first_length,
                              want.second_start, want.second_length, want.last);
                     $display("                got kind %0d %0d/%0d %0d/%0d last %0b",
                              rsp_tuser, rsp_tdata[9:0], rsp_tdata[20:10],
                              rsp_tdata[30:21], rsp_tdata[41:31], rsp_tlast);
                  end
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("url_field_tokenizer_unit test failed");
         $finish;
      end
   end

   initial begin
      enable_mask = 8'hFF;
      reset_parse();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // every event kind under the reset mask, illegal bytes, slash after port colon
      add_text("h://x:9/p?k=v");
      send_url(-1);
      push_byte(1'b0, 8'hFF);
      push_byte(1'b0, 8'h00);
      push_byte(1'b1, 8'hFF);
      add_text("a://b:/");
      send_url(-1);
      wait_drained();

      // full-length URL, then one character too many
      write_mask(8'hFF);
      add_text("/");
      add_run(SEG_SET, MAX_URL_LEN - 2, MAX_URL_LEN - 2);
      add_text("/");
      send_url(-1);
      add_text("/");
      add_run(SEG_SET, MAX_URL_LEN, MAX_URL_LEN);
      send_url(-1);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         send_gap_pct  = gap_by_phase[phase];
         rsp_stall_pct = stall_by_phase[phase];
         case (phase)
            0:       write_mask(8'h00);
            3:       write_mask(8'hFF);
            default: write_mask(8'($urandom_range(0, 255)));
         endcase
         fill_random(PHASE_BUDGET / 2);
         // hold the sender until every event has come back
         wait_drained();
         fill_random(PHASE_BUDGET / 2);
         wait_drained();
      end

      if (mismatch_count == 0) $display("url_field_tokenizer_unit test passed");
      else $display("url_field_tokenizer_unit test failed");
      $finish;
   end

endmodule
